// ===== sv/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parse phases, header constants and the result record shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

  localparam int FRAME_LEN_W = 16;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [FRAME_LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd4096;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DROP    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]             payload_byte;
    logic [3:0]             frame_opcode;
    logic                   last_of_frame;
    logic                   empty_frame;
    logic [FRAME_LEN_W-1:0] frame_length;
  } wsdf_result_t;

endpackage

`default_nettype wire

// ===== sv/wsdf_in_if.sv =====
// ----------------------------------------------------------------------------
// Raw byte channel
// Valid/ready channel carrying one received byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/wsdf_out_if.sv =====
// ----------------------------------------------------------------------------
// Deframed payload channel
// Valid/ready channel carrying one unmasked payload byte or empty-frame marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsdf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic        last_of_frame;
  logic        empty_frame;
  logic [15:0] frame_length;

  modport source (output valid, output payload_byte, output frame_opcode,
                  output last_of_frame, output empty_frame, output frame_length,
                  input ready);
  modport sink (input valid, input payload_byte, input frame_opcode,
                input last_of_frame, input empty_frame, input frame_length,
                output ready);
endinterface

`default_nettype wire

// ===== sv/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser: raw connection bytes in, unmasked payload out.
// ----------------------------------------------------------------------------
// Usage:
//   raw carries one received byte per word. deframed carries one unmasked
//   payload byte per word with the frame opcode, the clamped frame length and
//   a last flag; a frame whose kept length is zero gives a single word with
//   empty_frame and last_of_frame set and a zero payload byte.
//   Header, extended length, masking key and dropped bytes beyond the clamp
//   produce no output words.
//   Throughput is one byte per cycle while deframed does not stall. A payload
//   byte accepted on raw is registered in the output register, or first in the skid stage, before it reaches deframed.
//   When deframed stalls, one further result is parked in a skid stage and
//   raw.ready drops until the parked result has moved to the output.
//   cfg_we writes cfg_wdata into max_payload; write it only while idle. The
//   clamp is sampled when a frame's length completes.
//   A synchronous reset empties the output stages, sets max_payload to 4096
//   and returns the parser to the first header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_top
  import wsdf_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [FRAME_LEN_W-1:0] cfg_wdata,
  wsdf_in_if.sink                     raw,
  wsdf_out_if.source                  deframed
);

  logic [FRAME_LEN_W-1:0] max_payload;
  logic                   accept;
  logic                   buf_ready;
  logic                   res_valid;
  wsdf_result_t           res;
  wsdf_result_t           out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  assign raw.ready = buf_ready;
  assign accept    = raw.valid && buf_ready;

  wsdf_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (raw.data_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsdf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (buf_ready),
    .out_valid (deframed.valid),
    .out_res   (out_res),
    .out_ready (deframed.ready)
  );

  assign deframed.payload_byte  = out_res.payload_byte;
  assign deframed.frame_opcode  = out_res.frame_opcode;
  assign deframed.last_of_frame = out_res.last_of_frame;
  assign deframed.empty_frame   = out_res.empty_frame;
  assign deframed.frame_length  = out_res.frame_length;

endmodule

`default_nettype wire

// ===== sv/wsdf_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Header, length, masking key and payload tracking, one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_parser
  import wsdf_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             data_byte,
  input  wire logic [FRAME_LEN_W-1:0] max_payload,
  output logic                        res_valid,
  output wsdf_result_t                res
);

  localparam int CMP_W = (LENGTH_WIDTH > FRAME_LEN_W) ? LENGTH_WIDTH : FRAME_LEN_W;

  phase_t                  phase, phase_next;
  logic [3:0]              count, count_next;
  logic [3:0]              held_opcode, held_opcode_next;
  logic                    masked, masked_next;
  logic [LENGTH_WIDTH-1:0] declared, declared_next;
  logic [FRAME_LEN_W-1:0]  kept, kept_next;
  logic [LENGTH_WIDTH-1:0] position, position_next;
  logic [31:0]             mask_key, mask_key_next;

  logic [6:0]              len7;
  logic [LENGTH_WIDTH+7:0] ext_word;
  logic [LENGTH_WIDTH-1:0] ext_len;
  logic [LENGTH_WIDTH-1:0] hdr_len;
  logic [LENGTH_WIDTH-1:0] cand_len;
  logic [CMP_W-1:0]        cand_cmp;
  logic [FRAME_LEN_W-1:0]  cand_kept;
  logic [3:0]              cnt_inc;
  logic                    hdr_plain;
  logic                    ext_done;
  logic                    key_done;
  logic                    len_done;
  logic                    new_masked;
  logic                    begin_now;
  logic [FRAME_LEN_W-1:0]  begin_kept;
  logic [LENGTH_WIDTH-1:0] begin_decl;
  phase_t                  begin_phase;
  logic                    marker;
  logic [LENGTH_WIDTH-1:0] pos_inc;
  logic                    pay_last;
  logic [7:0]              key_byte;

  assign len7      = data_byte[6:0];
  assign ext_word  = {declared, data_byte};
  assign ext_len   = ext_word[LENGTH_WIDTH-1:0];
  assign hdr_len   = LENGTH_WIDTH'(len7);
  assign cand_len  = (phase == PH_HDR1) ? hdr_len : ext_len;
  assign cand_cmp  = CMP_W'(cand_len);
  assign cand_kept = (cand_cmp > CMP_W'(max_payload)) ? max_payload
                                                      : cand_cmp[FRAME_LEN_W-1:0];
  assign cnt_inc   = count + 4'd1;
  assign hdr_plain = (len7 != LEN_EXT16) && (len7 != LEN_EXT64);
  assign ext_done  = cnt_inc >= ((phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES);
  assign key_done  = (phase == PH_KEY) && (cnt_inc >= KEY_BYTES);
  assign len_done  = ((phase == PH_HDR1) && hdr_plain) ||
                     (((phase == PH_EXT16) || (phase == PH_EXT64)) && ext_done);
  assign new_masked = (phase == PH_HDR1) ? data_byte[7] : masked;
  assign begin_now  = (len_done && !new_masked) || key_done;
  assign begin_kept = (phase == PH_KEY) ? kept : cand_kept;
  assign begin_decl = (phase == PH_KEY) ? declared : cand_len;
  assign begin_phase = (begin_kept == '0) ?
                       ((begin_decl != '0) ? PH_DROP : PH_HDR0) : PH_PAYLOAD;
  assign marker    = begin_now && (begin_kept == '0);
  assign pos_inc   = position + LENGTH_WIDTH'(1);
  assign pay_last  = CMP_W'(pos_inc) >= CMP_W'(kept);

  always_comb begin
    case (position[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_HDR0: begin
          phase_next = PH_HDR1;
        end
        PH_HDR1: begin
          if (len7 == LEN_EXT16) begin
            phase_next = PH_EXT16;
          end else if (len7 == LEN_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            phase_next = new_masked ? PH_KEY : begin_phase;
          end
        end
        PH_EXT16, PH_EXT64: begin
          if (ext_done) begin
            phase_next = new_masked ? PH_KEY : begin_phase;
          end
        end
        PH_KEY: begin
          if (key_done) begin
            phase_next = begin_phase;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_next = (declared > pos_inc) ? PH_DROP : PH_HDR0;
          end
        end
        PH_DROP: begin
          if (pos_inc >= declared) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end
  end

  always_comb begin
    count_next       = count;
    held_opcode_next = held_opcode;
    masked_next      = masked;
    declared_next    = declared;
    kept_next        = kept;
    position_next    = position;
    mask_key_next    = mask_key;
    if (accept) begin
      case (phase)
        PH_HDR0: begin
          held_opcode_next = data_byte[3:0];
        end
        PH_HDR1: begin
          masked_next   = data_byte[7];
          mask_key_next = '0;
          count_next    = '0;
          declared_next = hdr_plain ? hdr_len : '0;
        end
        PH_EXT16, PH_EXT64: begin
          declared_next = ext_len;
          count_next    = ext_done ? 4'd0 : cnt_inc;
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], data_byte};
          count_next    = cnt_inc;
        end
        PH_PAYLOAD, PH_DROP: begin
          position_next = pos_inc;
        end
        default: begin
          count_next = count;
        end
      endcase
      if (len_done) begin
        kept_next = cand_kept;
      end
      if (begin_now) begin
        position_next = '0;
      end
    end

    res_valid         = accept && (marker || (phase == PH_PAYLOAD));
    res.payload_byte  = (phase == PH_PAYLOAD) ? (data_byte ^ key_byte) : 8'd0;
    res.frame_opcode  = held_opcode;
    res.last_of_frame = marker || pay_last;
    res.empty_frame   = marker;
    res.frame_length  = (phase == PH_PAYLOAD) ? kept : begin_kept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      count       <= '0;
      held_opcode <= '0;
      masked      <= 1'b0;
      declared    <= '0;
      kept        <= '0;
      position    <= '0;
      mask_key    <= '0;
    end else begin
      phase       <= phase_next;
      count       <= count_next;
      held_opcode <= held_opcode_next;
      masked      <= masked_next;
      declared    <= declared_next;
      kept        <= kept_next;
      position    <= position_next;
      mask_key    <= mask_key_next;
    end
  end

  a_result_needs_accept: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> accept)
    else $error("parser produced a result without an accepted byte");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.empty_frame) |-> res.last_of_frame)
    else $error("empty-frame marker not flagged as last");

  a_payload_has_length: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (kept != '0))
    else $error("payload phase entered with zero kept length");

endmodule

`default_nettype wire

// ===== sv/wsdf_out_buf.sv =====
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with a skid stage so the parser keeps taking bytes
// while a result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_out_buf
  import wsdf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire wsdf_result_t  in_res,
  output logic               in_ready,
  output logic               out_valid,
  output wsdf_result_t       out_res,
  input  wire logic          out_ready
);

  logic         skid_valid;
  wsdf_result_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_res   <= in_res;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
      skid_res   <= in_res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !out_ready) |=> skid_valid)
    else $error("result arriving during a stall was not parked");

  a_skid_moves_out: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("parked result did not move to the output");

endmodule

`default_nettype wire

// ===== tb/sv/tb_websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Drives raw bytes, mostly with random gaps on both channels. A scoreboard
// predicts every deframed word from its own parser and compares each field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_websocket_frame_deframer_top
  import wsdf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 4;
  localparam int PHASE_BYTES  = 70;
  localparam int PRINT_LIMIT  = 50;

  typedef enum logic [1:0] {
    ENC_SHORT,
    ENC_EXT16,
    ENC_EXT64
  } len_enc_t;

  class payload_scoreboard;
    logic [15:0]  max_payload;
    phase_t       phase;
    logic [3:0]   field_cnt;
    logic [3:0]   opcode;
    logic         masked;
    logic [15:0]  declared;
    logic [15:0]  kept;
    logic [15:0]  position;
    logic [31:0]  key;
    wsdf_result_t expected_words[$];
    int           mismatches;

    function new();
      max_payload = MAX_PAYLOAD_RESET;
      phase       = PH_HDR0;
      field_cnt   = '0;
      opcode      = '0;
      masked      = 1'b0;
      declared    = '0;
      kept        = '0;
      position    = '0;
      key         = '0;
      mismatches  = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void add_word(logic [7:0] data, logic last, logic empty);
      wsdf_result_t w;
      w.payload_byte  = data;
      w.frame_opcode  = opcode;
      w.last_of_frame = last;
      w.empty_frame   = empty;
      w.frame_length  = kept;
      expected_words.push_back(w);
    endfunction

    function void start_payload();
      position = '0;
      if (kept == 0) begin
        phase = (declared > 0) ? PH_DROP : PH_HDR0;
        add_word(8'h00, 1'b1, 1'b1);
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    function void close_length();
      kept = (declared > max_payload) ? max_payload : declared;
      if (masked) begin
        field_cnt = '0;
        phase     = PH_KEY;
      end else begin
        start_payload();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] kb;
      logic       last;
      case (phase)
        PH_HDR0: begin
          opcode = b[3:0];
          phase  = PH_HDR1;
        end
        PH_HDR1: begin
          masked    = b[7];
          key       = '0;
          field_cnt = '0;
          declared  = '0;
          if (b[6:0] == LEN_EXT16) begin
            phase = PH_EXT16;
          end else if (b[6:0] == LEN_EXT64) begin
            phase = PH_EXT64;
          end else begin
            declared = {9'd0, b[6:0]};
            close_length();
          end
        end
        PH_EXT16, PH_EXT64: begin
          declared  = {declared[7:0], b};
          field_cnt = field_cnt + 4'd1;
          if (field_cnt >= ((phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
            close_length();
          end
        end
        PH_KEY: begin
          key       = {key[23:0], b};
          field_cnt = field_cnt + 4'd1;
          if (field_cnt >= KEY_BYTES) begin
            start_payload();
          end
        end
        PH_PAYLOAD: begin
          kb       = key[8*(3-position[1:0]) +: 8];
          position = position + 16'd1;
          last     = (position >= kept);
          if (last) begin
            phase = (declared > position) ? PH_DROP : PH_HDR0;
          end
          add_word(b ^ kb, last, 1'b0);
        end
        PH_DROP: begin
          position = position + 16'd1;
          if (position >= declared) begin
            phase = PH_HDR0;
          end
        end
        default: begin
          phase = PH_HDR0;
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("mismatch %0d at %0t: %s got %h want %h", mismatches, $realtime, what,
                 got, want);
      end
    endtask

    task check_word(wsdf_result_t got);
      wsdf_result_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, payload_byte", 16'(got.payload_byte), 16'h0);
        return;
      end
      want = expected_words.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        report_mismatch("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      end
      if (got.frame_opcode !== want.frame_opcode) begin
        report_mismatch("frame_opcode", 16'(got.frame_opcode), 16'(want.frame_opcode));
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        report_mismatch("last_of_frame", 16'(got.last_of_frame), 16'(want.last_of_frame));
      end
      if (got.empty_frame !== want.empty_frame) begin
        report_mismatch("empty_frame", 16'(got.empty_frame), 16'(want.empty_frame));
      end
      if (got.frame_length !== want.frame_length) begin
        report_mismatch("frame_length", got.frame_length, want.frame_length);
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  bit          src_gaps;
  bit          sink_gaps;
  int          bytes_sent;
  int          cycle_count;

  payload_scoreboard sb = new();

  wsdf_in_if  raw();
  wsdf_out_if deframed();

  websocket_frame_deframer_top #(
    .LENGTH_WIDTH(16)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .raw      (raw),
    .deframed (deframed)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    deframed.ready <= !(sink_gaps && $urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    wsdf_result_t got;
    if (!rst && deframed.valid && deframed.ready) begin
      got.payload_byte  = deframed.payload_byte;
      got.frame_opcode  = deframed.frame_opcode;
      got.last_of_frame = deframed.last_of_frame;
      got.empty_frame   = deframed.empty_frame;
      got.frame_length  = deframed.frame_length;
      sb.check_word(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (src_gaps && $urandom_range(99) < 36) begin
      raw.valid <= 1'b0;
      @(negedge clk);
    end
    raw.valid     <= 1'b1;
    raw.data_byte <= b;
    do @(posedge clk); while (!raw.ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    raw.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_max(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.max_payload = value;
  endtask

  task automatic send_frame(input logic [7:0] first, input logic masked, input logic [15:0] len,
                            input len_enc_t enc, input int unsigned sent);
    send_byte(first);
    case (enc)
      ENC_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      ENC_EXT64: begin
        send_byte({masked, LEN_EXT64});
        repeat (6) send_byte(8'($urandom));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, len[6:0]});
      end
    endcase
    if (masked) begin
      repeat (KEY_BYTES) send_byte(8'($urandom));
    end
    repeat (sent) send_byte(8'($urandom));
  endtask

  // Completes whatever frame the parser is in with short, bounded field values.
  task automatic finish_frame();
    while (sb.phase != PH_HDR0) begin
      case (sb.phase)
        PH_HDR1: begin
          send_byte({1'($urandom), 7'($urandom_range(20))});
        end
        PH_EXT16, PH_EXT64: begin
          if (sb.field_cnt == ((sb.phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES) - 4'd1)
            send_byte(8'($urandom_range(40)));
          else
            send_byte(8'h00);
        end
        default: begin
          send_byte(8'($urandom));
        end
      endcase
    end
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned kind;
    logic [15:0] len;
    len_enc_t    enc;
    kind = $urandom_range(99);
    if (kind < 80) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        enc = ENC_SHORT;
        len = 16'($urandom_range(20));
      end else if (pick < 80) begin
        enc = ENC_SHORT;
        len = 16'($urandom_range(125));
      end else if (pick < 90) begin
        enc = ENC_EXT16;
        len = 16'($urandom_range(150));
      end else begin
        enc = ENC_EXT64;
        len = 16'($urandom_range(150));
      end
      send_frame(8'($urandom), 1'($urandom), len, enc, len);
    end else if (kind < 90) begin
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      finish_frame();
    end else begin
      // A frame cut short; the following header bytes, or at least the first of them, are swallowed as its payload.
      len = 16'($urandom_range(30, 4));
      send_frame(8'($urandom), 1'($urandom), len, ENC_SHORT, $urandom_range(len - 1));
      send_byte(8'h81);
      send_byte(8'h05);
      finish_frame();
    end
  endtask

  initial begin
    logic [15:0] settings[7];
    int          start;
    raw.valid      = 1'b0;
    raw.data_byte  = 8'h00;
    deframed.ready = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 16'h0000;
    rst            = 1'b1;
    src_gaps       = 1'b1;
    sink_gaps      = 1'b1;
    bytes_sent     = 0;
    cycle_count    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_frame(8'h89, 1'b0, 16'd0, ENC_SHORT, 0);
    send_frame(8'hF1, 1'b0, 16'd2, ENC_SHORT, 2);
    send_frame(8'h82, 1'b1, 16'd5, ENC_SHORT, 5);
    send_frame(8'h8A, 1'b1, 16'd0, ENC_SHORT, 0);
    send_frame(8'h02, 1'b0, 16'd2, ENC_EXT16, 2);
    send_frame(8'h00, 1'b1, 16'd1, ENC_EXT64, 1);
    write_max(16'd2);
    send_frame(8'h01, 1'b1, 16'd4, ENC_SHORT, 0);
    write_max(16'hFFFF);
    repeat (4) send_byte(8'($urandom));

    settings[0] = 16'd0;
    settings[1] = 16'hFFFF;
    settings[2] = 16'd1;
    settings[3] = 16'd3;
    settings[4] = 16'($urandom_range(60, 4));
    settings[5] = MAX_PAYLOAD_RESET;
    settings[6] = 16'($urandom);
    for (int i = 0; i < 7; i++) begin
      write_max(settings[i]);
      src_gaps  = (i != 3);
      sink_gaps = (i != 3);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_sequence();
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
